// File: rtl/wis_pkg.sv
package wis_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int TOT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int MAX_CYCLE   = 48;
  localparam int RESULT_MAX  = 48;
  localparam int CAP         = (MAX_CYCLE < RESULT_MAX) ? MAX_CYCLE : RESULT_MAX;
  localparam int CNT_W       = 8;
  localparam int SUM_W       = 12;
  localparam int DVD_W       = 15;
  localparam int DEN_W       = 13;
  localparam int DIV_STEPS   = DVD_W;
  localparam int STEP_W      = $clog2(DIV_STEPS + 1);
  localparam int POS_W       = 6;
  localparam int EMIT_W      = 6;
  localparam int D_W         = 20;

  typedef struct packed {
    logic [7:0] component_id;
    logic [7:0] weight;
    logic       last_entry;
  } in_item_t;

  typedef struct packed {
    logic [7:0] sequence_id;
    logic       last_of_run;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_STORE,
    OP_GINIT,
    OP_GLD,
    OP_GSTEP,
    OP_DLD,
    OP_DSTEP,
    OP_DWR,
    OP_SINIT,
    OP_SLD,
    OP_SWR,
    OP_MINIT,
    OP_MSCAN,
    OP_MDEC,
    OP_EINIT,
    OP_ESCAN,
    OP_EOUT,
    OP_ENEXT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic gb_zero;
    logic div_done;
    logic sum_gt_cap;
    logic best_le1;
    logic out_busy;
    logic pos_last;
  } dp_sts_t;

endpackage

// File: rtl/weighted_interleave_sequencer_core.sv
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_stall   | in_item  (component_id, weight, last_entry)
// out     | output    | out_valid / out_stall | out_item (sequence_id, last_of_run)
//
// List entries are taken one per cycle while in_stall is low. On the last entry
// the block stalls its input while a gcd pass (subtractive, per entry), a 15-step
// divider pass per entry, an optional rescale pass and largest-count trim run;
// each position then scans every stored entry and passes through the output
// register. Reset is synchronous, active low. A stalled output holds its item
// and pauses the sequence; the input stays stalled until the run ends.
module weighted_interleave_sequencer_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  wis_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output wis_pkg::out_item_t  out_item
);
  import wis_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  wis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_item.last_entry),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  wis_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// File: rtl/wis_dp.sv
module wis_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  wis_pkg::dp_cmd_t  cmd,
  output wis_pkg::dp_sts_t  sts,
  input  wis_pkg::in_item_t in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output wis_pkg::out_item_t out_item
);
  import wis_pkg::*;

  logic [7:0]        id_r   [MAX_ENTRIES];
  logic [CNT_W-1:0]  cnt_r  [MAX_ENTRIES];
  logic [EMIT_W-1:0] emit_r [MAX_ENTRIES];

  logic [TOT_W-1:0]  total_r;
  logic              anynz_r;
  logic [IDX_W-1:0]  idx_r;
  logic [CNT_W-1:0]  ga_r, gb_r, g_r;
  logic [SUM_W-1:0]  sum_r, old_r;
  logic [DEN_W-1:0]  rem_r, den_r;
  logic [DVD_W-1:0]  quo_r;
  logic [STEP_W-1:0] step_r;
  logic [IDX_W-1:0]  best_r;
  logic [CNT_W-1:0]  bcnt_r;
  logic signed [D_W-1:0] bdef_r;
  logic              bvalid_r;
  logic [POS_W-1:0]  pos_r;
  logic              out_valid_r;
  out_item_t         out_r;

  logic [CNT_W-1:0]  cur_cnt, eff;
  logic              act, idx_last;
  logic [IDX_W-1:0]  idx_inc;
  logic [DEN_W:0]    div_t, div_diff;
  logic              div_ge;
  logic [SUM_W-1:0]  limit;
  logic [CNT_W-1:0]  q8, qmin1;
  logic [POS_W:0]    p1;
  logic [14:0]       prod1;
  logic [17:0]       prod2;
  logic signed [D_W-1:0] dcur;

  // Current entry view
  assign cur_cnt  = cnt_r[idx_r];
  assign act      = !anynz_r || (cur_cnt != '0);
  assign eff      = anynz_r ? cur_cnt : CNT_W'(1);
  assign idx_last = (TOT_W'(idx_r) == total_r - TOT_W'(1));
  assign idx_inc  = idx_last ? '0 : idx_r + IDX_W'(1);

  // Restoring divider step
  assign div_t    = {rem_r, quo_r[DVD_W-1]};
  assign div_ge   = div_t >= {1'b0, den_r};
  assign div_diff = div_t - {1'b0, den_r};
  assign q8       = quo_r[CNT_W-1:0];
  assign qmin1    = (quo_r == '0) ? CNT_W'(1) : q8;

  // Deficit of the current entry
  assign p1    = {1'b0, pos_r} + (POS_W+1)'(1);
  assign prod1 = 15'(p1) * 15'(cur_cnt);
  assign prod2 = 18'(emit_r[idx_r]) * 18'(sum_r);
  assign dcur  = $signed(D_W'(prod1)) - $signed(D_W'(prod2));

  assign limit = (sum_r > SUM_W'(CAP)) ? SUM_W'(CAP) : sum_r;

  assign sts.idx_last   = idx_last;
  assign sts.gb_zero    = (gb_r == '0);
  assign sts.div_done   = (step_r == STEP_W'(DIV_STEPS));
  assign sts.sum_gt_cap = (sum_r > SUM_W'(CAP));
  assign sts.best_le1   = (bcnt_r <= CNT_W'(1));
  assign sts.out_busy   = out_valid_r;
  assign sts.pos_last   = (SUM_W'(pos_r) + SUM_W'(1) == limit);

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      anynz_r     <= 1'b0;
      idx_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
      bvalid_r    <= 1'b0;
      sum_r       <= '0;
      step_r      <= '0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (cmd.op)
        OP_STORE: begin
          if (total_r < TOT_W'(MAX_ENTRIES)) begin
            total_r <= total_r + TOT_W'(1);
            if (in_item.weight != '0) anynz_r <= 1'b1;
          end
        end
        OP_GINIT: idx_r <= '0;
        OP_GSTEP: begin
          if (gb_r == '0) begin
            idx_r <= idx_inc;
            if (idx_last) sum_r <= '0;
          end
        end
        OP_DLD:   step_r <= '0;
        OP_DSTEP: step_r <= step_r + STEP_W'(1);
        OP_DWR: begin
          if (act) sum_r <= sum_r + SUM_W'(q8);
          idx_r <= idx_inc;
        end
        OP_SINIT: begin
          sum_r <= '0;
          idx_r <= '0;
        end
        OP_SLD: step_r <= '0;
        OP_SWR: begin
          if (act) sum_r <= sum_r + SUM_W'(qmin1);
          idx_r <= idx_inc;
        end
        OP_MINIT: begin
          idx_r    <= '0;
          bvalid_r <= 1'b0;
        end
        OP_MSCAN: begin
          if (act && (!bvalid_r || cur_cnt > bcnt_r)) bvalid_r <= 1'b1;
          idx_r <= idx_inc;
        end
        OP_MDEC: sum_r <= sum_r - SUM_W'(1);
        OP_EINIT: begin
          pos_r    <= '0;
          idx_r    <= '0;
          bvalid_r <= 1'b0;
        end
        OP_ESCAN: begin
          if (act && (!bvalid_r || dcur > bdef_r)) bvalid_r <= 1'b1;
          idx_r <= idx_inc;
        end
        OP_EOUT: begin
          out_valid_r <= 1'b1;
          bvalid_r    <= 1'b0;
        end
        OP_ENEXT: begin
          if (sts.pos_last) begin
            total_r <= '0;
            anynz_r <= 1'b0;
            pos_r   <= '0;
          end else begin
            pos_r <= pos_r + POS_W'(1);
          end
          idx_r <= '0;
        end
        default: ;
      endcase
    end
  end

  // Payload registers and entry stores
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_STORE: begin
        if (total_r < TOT_W'(MAX_ENTRIES)) begin
          id_r[total_r[IDX_W-1:0]]  <= in_item.component_id;
          cnt_r[total_r[IDX_W-1:0]] <= in_item.weight;
        end
      end
      OP_GINIT: g_r <= '0;
      OP_GLD: begin
        ga_r <= g_r;
        gb_r <= act ? eff : '0;
      end
      OP_GSTEP: begin
        if (gb_r == '0) begin
          g_r <= ga_r;
        end else if (ga_r >= gb_r) begin
          ga_r <= ga_r - gb_r;
        end else begin
          ga_r <= gb_r;
          gb_r <= ga_r;
        end
      end
      OP_DLD: begin
        rem_r <= '0;
        quo_r <= DVD_W'(eff);
        den_r <= DEN_W'(g_r);
      end
      OP_DSTEP: begin
        rem_r <= div_ge ? div_diff[DEN_W-1:0] : div_t[DEN_W-1:0];
        quo_r <= {quo_r[DVD_W-2:0], div_ge};
      end
      OP_DWR: if (act) cnt_r[idx_r] <= q8;
      OP_SINIT: old_r <= sum_r;
      OP_SLD: begin
        rem_r <= '0;
        quo_r <= DVD_W'(cur_cnt) * DVD_W'(2 * CAP) + DVD_W'(old_r);
        den_r <= {old_r, 1'b0};
      end
      OP_SWR: if (act) cnt_r[idx_r] <= qmin1;
      OP_MSCAN: begin
        if (act && (!bvalid_r || cur_cnt > bcnt_r)) begin
          best_r <= idx_r;
          bcnt_r <= cur_cnt;
        end
      end
      OP_MDEC: cnt_r[best_r] <= bcnt_r - CNT_W'(1);
      OP_EINIT: begin
        for (int i = 0; i < MAX_ENTRIES; i++) emit_r[i] <= '0;
      end
      OP_ESCAN: begin
        if (act && (!bvalid_r || dcur > bdef_r)) begin
          best_r <= idx_r;
          bdef_r <= dcur;
        end
      end
      OP_EOUT: begin
        out_r.sequence_id <= id_r[best_r];
        out_r.last_of_run <= sts.pos_last;
        emit_r[best_r]    <= emit_r[best_r] + EMIT_W'(1);
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/wis_ctrl.sv
module wis_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_stall,
  input  logic             out_stall,
  input  wis_pkg::dp_sts_t sts,
  output wis_pkg::dp_cmd_t cmd
);
  import wis_pkg::*;

  typedef enum logic [13:0] {
    S_LOAD  = 14'b00000000000001,
    S_GINIT = 14'b00000000000010,
    S_GLD   = 14'b00000000000100,
    S_GIT   = 14'b00000000001000,
    S_DLD   = 14'b00000000010000,
    S_DIV   = 14'b00000000100000,
    S_CHK   = 14'b00000001000000,
    S_SLD   = 14'b00000010000000,
    S_SDIV  = 14'b00000100000000,
    S_MCHK  = 14'b00001000000000,
    S_MSCAN = 14'b00010000000000,
    S_MDEC  = 14'b00100000000000,
    S_ESCAN = 14'b01000000000000,
    S_EWAIT = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_LOAD);

  // Sequence the list build and emission
  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_IDLE;
    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          cmd.op = OP_STORE;
          if (in_last) state_nxt = S_GINIT;
        end
      end
      S_GINIT: begin
        cmd.op    = OP_GINIT;
        state_nxt = S_GLD;
      end
      S_GLD: begin
        cmd.op    = OP_GLD;
        state_nxt = S_GIT;
      end
      S_GIT: begin
        cmd.op = OP_GSTEP;
        if (sts.gb_zero) state_nxt = sts.idx_last ? S_DLD : S_GLD;
      end
      S_DLD: begin
        cmd.op    = OP_DLD;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (!sts.div_done) begin
          cmd.op = OP_DSTEP;
        end else begin
          cmd.op    = OP_DWR;
          state_nxt = sts.idx_last ? S_CHK : S_DLD;
        end
      end
      S_CHK: begin
        if (sts.sum_gt_cap) begin
          cmd.op    = OP_SINIT;
          state_nxt = S_SLD;
        end else begin
          cmd.op    = OP_EINIT;
          state_nxt = S_ESCAN;
        end
      end
      S_SLD: begin
        cmd.op    = OP_SLD;
        state_nxt = S_SDIV;
      end
      S_SDIV: begin
        if (!sts.div_done) begin
          cmd.op = OP_DSTEP;
        end else begin
          cmd.op    = OP_SWR;
          state_nxt = sts.idx_last ? S_MCHK : S_SLD;
        end
      end
      S_MCHK: begin
        if (sts.sum_gt_cap) begin
          cmd.op    = OP_MINIT;
          state_nxt = S_MSCAN;
        end else begin
          cmd.op    = OP_EINIT;
          state_nxt = S_ESCAN;
        end
      end
      S_MSCAN: begin
        cmd.op = OP_MSCAN;
        if (sts.idx_last) state_nxt = S_MDEC;
      end
      S_MDEC: begin
        if (sts.best_le1) begin
          cmd.op    = OP_EINIT;
          state_nxt = S_ESCAN;
        end else begin
          cmd.op    = OP_MDEC;
          state_nxt = S_MCHK;
        end
      end
      S_ESCAN: begin
        cmd.op = OP_ESCAN;
        if (sts.idx_last) state_nxt = S_EWAIT;
      end
      S_EWAIT: begin
        // load the output once, then hold until taken
        if (!sts.out_busy) begin
          cmd.op = OP_EOUT;
        end else if (!out_stall) begin
          cmd.op    = OP_ENEXT;
          state_nxt = sts.pos_last ? S_LOAD : S_ESCAN;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: dv/weighted_interleave_sequencer_core_tb.sv
module weighted_interleave_sequencer_core_tb;
  import wis_pkg::*;

  localparam int ENTRY_CAP = 16;
  localparam int CYCLE_CAP = 48;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  weighted_interleave_sequencer_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  // predictor state: the open list
  logic [7:0] list_ids[ENTRY_CAP];
  logic [7:0] list_wts[ENTRY_CAP];
  int         list_len;
  out_item_t  pending_seq[$];
  int         err_cnt;
  bit         idle_on;
  bit         hold_off;

  initial begin
    clk = 1'b0;
  end
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int gcd_of(int a, int b);
    int t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // build the interleaved cycle for the closed list and queue its items
  task automatic build_sequence();
    logic [7:0] ids[ENTRY_CAP];
    int cnt[ENTRY_CAP];
    int emit[ENTRY_CAP];
    int n, g, total, old, best, bdef, d, lim;
    out_item_t r;
    n = 0; g = 0; total = 0;
    for (int i = 0; i < list_len; i++)
      if (list_wts[i] != 0) begin
        ids[n] = list_ids[i]; cnt[n] = list_wts[i]; n++;
      end
    if (n == 0) begin
      for (int i = 0; i < list_len; i++) begin
        ids[i] = list_ids[i]; cnt[i] = 1;
      end
      n = list_len;
    end
    for (int i = 0; i < n; i++) g = gcd_of(g, cnt[i]);
    if (g > 1) for (int i = 0; i < n; i++) cnt[i] = cnt[i] / g;
    for (int i = 0; i < n; i++) total += cnt[i];
    if (total > CYCLE_CAP) begin
      old = total;
      total = 0;
      for (int i = 0; i < n; i++) begin
        cnt[i] = (2 * cnt[i] * CYCLE_CAP + old) / (2 * old);
        if (cnt[i] < 1) cnt[i] = 1;
        total += cnt[i];
      end
      while (total > CYCLE_CAP) begin
        best = 0;
        for (int i = 1; i < n; i++) if (cnt[i] > cnt[best]) best = i;
        if (cnt[best] <= 1) break;
        cnt[best]--;
        total--;
      end
    end
    lim = (total < CYCLE_CAP) ? total : CYCLE_CAP;
    for (int i = 0; i < n; i++) emit[i] = 0;
    for (int p = 0; p < lim; p++) begin
      best = 0; bdef = 0;
      for (int i = 0; i < n; i++) begin
        d = (p + 1) * cnt[i] - emit[i] * total;
        if (i == 0 || d > bdef) begin
          bdef = d; best = i;
        end
      end
      emit[best]++;
      r.sequence_id = ids[best];
      r.last_of_run = (p + 1 == lim);
      pending_seq = {pending_seq, r};
    end
    list_len = 0;
  endtask

  // record one accepted entry
  task automatic absorb_entry(in_item_t it);
    if (list_len < ENTRY_CAP) begin
      list_ids[list_len] = it.component_id;
      list_wts[list_len] = it.weight;
      list_len++;
    end
    if (it.last_entry) build_sequence();
  endtask

  // offer one item, with random idle cycles ahead of it
  task automatic send_entry(logic [7:0] id, logic [7:0] wt, logic lst);
    in_item_t it;
    it.component_id = id;
    it.weight = wt;
    it.last_entry = lst;
    while (idle_on && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    absorb_entry(it);
  endtask

  // drop valid, then wait for every expected item
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_seq.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= hold_off || (idle_on && $urandom_range(99) < 12);
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_seq.size() == 0) begin
        $display("%0t: unexpected item actual id=%0h last=%0b", $time,
                 out_item.sequence_id, out_item.last_of_run);
        err_cnt++;
      end else begin
        want = pending_seq.pop_front();
        if (out_item.sequence_id !== want.sequence_id) begin
          $display("%0t: sequence_id expected %0h actual %0h", $time,
                   want.sequence_id, out_item.sequence_id);
          err_cnt++;
        end
        if (out_item.last_of_run !== want.last_of_run) begin
          $display("%0t: last_of_run expected %0b actual %0b", $time,
                   want.last_of_run, out_item.last_of_run);
          err_cnt++;
        end
      end
    end
  end

  task automatic test_directed();
    // single entry, zero weight
    send_entry(8'h00, 8'h00, 1'b1);
    // single entry, full weight
    send_entry(8'hFF, 8'hFF, 1'b1);
    // all weights zero
    send_entry(8'h11, 8'h00, 1'b0);
    send_entry(8'h22, 8'h00, 1'b1);
    // zero weight dropped, gcd reduction
    send_entry(8'hA5, 8'h06, 1'b0);
    send_entry(8'h5A, 8'h00, 1'b0);
    send_entry(8'h3C, 8'h04, 1'b1);
    // sum above the cap: rescale and trim
    send_entry(8'h01, 8'hFF, 1'b0);
    send_entry(8'h02, 8'h01, 1'b0);
    send_entry(8'h03, 8'h80, 1'b1);
    // ties go to first entry
    send_entry(8'h0A, 8'h07, 1'b0);
    send_entry(8'h0B, 8'h07, 1'b1);
    wait_drained();
  endtask

  task automatic test_full_list();
    // overfull list, distinct prime-ish weights, cycle beyond cap
    for (int i = 0; i < 20; i++)
      send_entry(i[7:0], 8'(61 + 2 * i), i == 19);
    wait_drained();
  endtask

  task automatic test_random();
    int len;
    int sent;
    sent = 0;
    while (sent < 400) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        send_entry(8'($urandom_range(255)),
                   ($urandom_range(3) == 0) ? 8'($urandom_range(255)) :
                   ($urandom_range(4) == 0) ? 8'h00 : 8'($urandom_range(1, 12)),
                   i == len - 1);
        sent++;
      end
      if (sent > 150 && sent < 200) idle_on = 1'b0;
      else idle_on = 1'b1;
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    // receiver holds off while sender keeps offering
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < 12; i++)
          send_entry(8'($urandom_range(255)), 8'($urandom_range(1, 20)), (i % 4) == 3);
      end
    join
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    err_cnt = 0;
    list_len = 0;
    idle_on = 1'b1;
    hold_off = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_list();
    test_backpressure();
    test_random();
    if (err_cnt == 0 && pending_seq.size() == 0)
      $display("weighted_interleave_sequencer_core_tb: clean");
    else
      $display("weighted_interleave_sequencer_core_tb: errors");
    $finish;
  end

  initial begin
    #60000000;
    $display("weighted_interleave_sequencer_core_tb: errors");
    $finish;
  end

endmodule
